>>> src/unpm_pkg.sv
package unpm_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned RecipW = 32;
  localparam int unsigned ProdW  = PixW + RecipW;
  // Reciprocal scale: quotient = (colour * recip) >> RecipShift
  localparam int unsigned RecipShift = 24;

  localparam logic [PixW-1:0] AlphaZero = '0;
  localparam logic [PixW-1:0] AlphaFull = '1;
  localparam logic [PixW-1:0] PixMax    = '1;

  typedef struct packed {
    logic [PixW-1:0] in_blue;
    logic [PixW-1:0] in_green;
    logic [PixW-1:0] in_red;
    logic [PixW-1:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_byte0;
    logic [PixW-1:0] out_byte1;
    logic [PixW-1:0] out_byte2;
    logic [PixW-1:0] out_byte3;
  } pix_out_t;

  // after reciprocal lookup
  typedef struct packed {
    pix_in_t           px;
    logic [RecipW-1:0] recip;
  } rcp_stage_t;

  // after the multipliers
  typedef struct packed {
    pix_in_t          px;
    logic [ProdW-1:0] prod_r;
    logic [ProdW-1:0] prod_g;
    logic [ProdW-1:0] prod_b;
  } mul_stage_t;

endpackage

>>> src/unpm_recip.sv
module unpm_recip (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 v_in,
  input  unpm_pkg::pix_in_t    d_in,
  output logic                 rdy_up,
  output logic                 v_r,
  output unpm_pkg::rcp_stage_t d_r,
  input  logic                 rdy_dn
);

  localparam int unsigned Depth = 2 ** unpm_pkg::PixW;

  logic [unpm_pkg::RecipW-1:0] recip_tbl [Depth];
  logic                        adv;
  unpm_pkg::rcp_stage_t        d_nxt;

  // recip_tbl[a] = 255 * ceil(2^24 / a); exact floor(c*255/a) for all 8-bit c and nonzero a
  for (genvar a = 0; a < Depth; a++) begin : g_tbl
    localparam longint unsigned Ceil = (a == 0) ? 64'd0 :
      ((64'd1 << unpm_pkg::RecipShift) + 64'(a) - 64'd1) / 64'(a);
    localparam longint unsigned Scaled = Ceil * 64'(unpm_pkg::PixMax);
    assign recip_tbl[a] = Scaled[unpm_pkg::RecipW-1:0];
  end

  assign adv    = !v_r || rdy_dn;
  assign rdy_up = adv;

  always_comb begin
    d_nxt.px    = d_in;
    d_nxt.recip = recip_tbl[d_in.in_alpha];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_in) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> src/unpm_mul.sv
module unpm_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 v_in,
  input  unpm_pkg::rcp_stage_t d_in,
  output logic                 rdy_up,
  output logic                 v_r,
  output unpm_pkg::mul_stage_t d_r,
  input  logic                 rdy_dn
);

  logic                 adv;
  unpm_pkg::mul_stage_t d_nxt;

  assign adv    = !v_r || rdy_dn;
  assign rdy_up = adv;

  always_comb begin
    d_nxt.px     = d_in.px;
    d_nxt.prod_r = unpm_pkg::ProdW'(d_in.px.in_red)   * unpm_pkg::ProdW'(d_in.recip);
    d_nxt.prod_g = unpm_pkg::ProdW'(d_in.px.in_green) * unpm_pkg::ProdW'(d_in.recip);
    d_nxt.prod_b = unpm_pkg::ProdW'(d_in.px.in_blue)  * unpm_pkg::ProdW'(d_in.recip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_in) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> src/unpm_sel.sv
module unpm_sel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 v_in,
  input  unpm_pkg::mul_stage_t d_in,
  output logic                 rdy_up,
  output logic                 v_r,
  output unpm_pkg::pix_out_t   d_r,
  input  logic                 rdy_dn
);

  localparam int unsigned QLo = unpm_pkg::RecipShift;
  localparam int unsigned QHi = QLo + unpm_pkg::PixW - 1;

  logic                      adv;
  logic [unpm_pkg::PixW-1:0] q_r;
  logic [unpm_pkg::PixW-1:0] q_g;
  logic [unpm_pkg::PixW-1:0] q_b;
  unpm_pkg::pix_out_t        d_nxt;

  assign adv    = !v_r || rdy_dn;
  assign rdy_up = adv;

  // any bit above the 8-bit quotient means overflow -> saturate
  assign q_r = (|d_in.prod_r[unpm_pkg::ProdW-1:QHi+1]) ? unpm_pkg::PixMax
                                                       : d_in.prod_r[QHi:QLo];
  assign q_g = (|d_in.prod_g[unpm_pkg::ProdW-1:QHi+1]) ? unpm_pkg::PixMax
                                                       : d_in.prod_g[QHi:QLo];
  assign q_b = (|d_in.prod_b[unpm_pkg::ProdW-1:QHi+1]) ? unpm_pkg::PixMax
                                                       : d_in.prod_b[QHi:QLo];

  always_comb begin
    d_nxt.out_byte3 = d_in.px.in_alpha;
    if (d_in.px.in_alpha == unpm_pkg::AlphaZero) begin
      d_nxt.out_byte0 = d_in.px.in_blue;
      d_nxt.out_byte1 = d_in.px.in_green;
      d_nxt.out_byte2 = d_in.px.in_red;
    end else if (d_in.px.in_alpha == unpm_pkg::AlphaFull) begin
      d_nxt.out_byte0 = d_in.px.in_red;
      d_nxt.out_byte1 = d_in.px.in_green;
      d_nxt.out_byte2 = d_in.px.in_blue;
    end else begin
      d_nxt.out_byte0 = q_r;
      d_nxt.out_byte1 = q_g;
      d_nxt.out_byte2 = q_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_in) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> src/unpremultiply_bgra_to_rgba.sv
// Alpha unpremultiply with BGRA to RGBA reorder. Takes one premultiplied pixel
// (blue, green, red, alpha) per item and returns one four-byte item: with alpha
// zero the bytes pass through in input order; with alpha 255 red and blue swap;
// otherwise each colour becomes floor(colour*255/alpha), saturated to 255, in
// red, green, blue order. Alpha is kept. Three register stages (reciprocal
// table lookup, multipliers, saturate/select into the output register); one item
// is accepted every cycle while out_stall is low. A stall holds a full stage only
// when every stage ahead of it is full; empty stages keep filling behind it.
module unpremultiply_bgra_to_rgba (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  unpm_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output unpm_pkg::pix_out_t out_data
);

  logic                 rcp_v;
  logic                 rcp_rdy;
  unpm_pkg::rcp_stage_t rcp_d;
  logic                 mul_v;
  logic                 mul_rdy;
  unpm_pkg::mul_stage_t mul_d;
  logic                 in_rdy;
  logic                 sel_rdy;

  assign in_stall = !in_rdy;

  unpm_recip u_recip (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_in   (in_valid),
    .d_in   (in_data),
    .rdy_up (in_rdy),
    .v_r    (rcp_v),
    .d_r    (rcp_d),
    .rdy_dn (rcp_rdy)
  );

  unpm_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_in   (rcp_v),
    .d_in   (rcp_d),
    .rdy_up (rcp_rdy),
    .v_r    (mul_v),
    .d_r    (mul_d),
    .rdy_dn (mul_rdy)
  );

  unpm_sel u_sel (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_in   (mul_v),
    .d_in   (mul_d),
    .rdy_up (sel_rdy),
    .v_r    (out_valid),
    .d_r    (out_data),
    .rdy_dn (!out_stall)
  );

  assign mul_rdy = sel_rdy;

endmodule
